### design/mll_pkg.sv
package mll_pkg;

  localparam int MAX_LINE = 4096;
  localparam int OFF_W    = $clog2(MAX_LINE + 1);

  localparam int KIND_W  = 5;
  localparam int START_W = 12;
  localparam int LEN_W   = 13;

  localparam logic [START_W-1:0] START_MAX = {START_W{1'b1}};
  localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(4096);

  localparam logic [KIND_W-1:0] KIND_STRING  = 5'd12;
  localparam logic [KIND_W-1:0] KIND_WORD    = 5'd13;
  localparam logic [KIND_W-1:0] KIND_KW0     = 5'd14;
  localparam logic [KIND_W-1:0] KIND_OTHER   = 5'd20;
  localparam logic [KIND_W-1:0] KIND_UNTERM  = 5'd21;
  localparam logic [KIND_W-1:0] KIND_END     = 5'd22;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam int NUM_PUNCT = 12;
  localparam logic [7:0] PUNCT [NUM_PUNCT] = '{
    8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h3D, 8'h5E, 8'h2A, 8'h2B, 8'h40, 8'h26, 8'h7E, 8'h2C
  };

  localparam int NUM_KW  = 6;
  localparam int KW_CHARS = 9;
  localparam logic [7:0] KW_TEXT [NUM_KW][KW_CHARS] = '{
    '{8'h64, 8'h6F, 8'h6E, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // done
    '{8'h72, 8'h75, 8'h6E, 8'h6E, 8'h69, 8'h6E, 8'h67, 8'h00, 8'h00},  // running
    '{8'h63, 8'h6F, 8'h6E, 8'h6E, 8'h65, 8'h63, 8'h74, 8'h65, 8'h64},  // connected
    '{8'h65, 8'h72, 8'h72, 8'h6F, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00},  // error
    '{8'h65, 8'h78, 8'h69, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // exit
    '{8'h73, 8'h74, 8'h6F, 8'h70, 8'h70, 8'h65, 8'h64, 8'h00, 8'h00}   // stopped
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd4, 4'd7, 4'd9, 4'd5, 4'd4, 4'd7};

  localparam int MAX_TOK = 3;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
  } tok_t;

  typedef struct packed {
    logic [1:0]             cnt;
    tok_t [MAX_TOK-1:0]     tok;
  } bundle_t;

  function automatic logic is_word_char(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h30 && b <= 8'h39) || b == CH_DASH || b == CH_UNDER;
  endfunction

  function automatic logic [START_W-1:0] sat_start(input logic [OFF_W-1:0] x);
    return (x > OFF_W'(START_MAX)) ? START_MAX : START_W'(x);
  endfunction

  function automatic logic [LEN_W-1:0] span(input logic [OFF_W-1:0] e,
                                            input logic [OFF_W-1:0] s);
    logic [OFF_W-1:0] d;
    d = (e >= s) ? e - s : '0;
    return (d > OFF_W'(LEN_MAX)) ? LEN_MAX : LEN_W'(d);
  endfunction

endpackage

### design/mll_front.sv
module mll_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  input  logic              line_end_i,
  output logic              push_o,
  output mll_pkg::bundle_t  bundle_o
);
  import mll_pkg::*;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_WORD   = 4'b0010,
    MODE_STRING = 4'b0100,
    MODE_ESC    = 4'b1000
  } mode_e;

  mode_e            mode_q, mode_d;
  logic [OFF_W-1:0] offset_q, offset_d;
  logic [OFF_W-1:0] begin_q, begin_d;
  logic [5:0]       mask_q, mask_d;
  logic [3:0]       widx_q, widx_d;

  function automatic logic [5:0] word_add(input logic [5:0] m, input logic [3:0] idx,
                                          input logic [7:0] b);
    logic [5:0] r;
    r = m;
    for (int k = 0; k < NUM_KW; k++) begin
      if (idx >= 4'(KW_CHARS) || KW_TEXT[k][idx] != b) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [KIND_W-1:0] close_kind(input logic [5:0] m, input logic [3:0] idx);
    logic [KIND_W-1:0] r;
    r = KIND_WORD;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (m[k] && idx == KW_LEN[k]) begin
        r = KIND_KW0 + KIND_W'(k);
      end
    end
    return r;
  endfunction

  always_comb begin
    logic [OFF_W-1:0] cur;
    logic [OFF_W-1:0] nxt;
    logic [1:0]       n;
    logic             do_idle;
    logic             hit;
    logic [3:0]       pidx;

    cur      = offset_q;
    nxt      = (cur < OFF_W'(MAX_LINE)) ? cur + 1'b1 : OFF_W'(MAX_LINE);
    n        = '0;
    do_idle  = 1'b0;
    hit      = 1'b0;
    pidx     = '0;
    bundle_o = '0;
    mode_d   = mode_q;
    begin_d  = begin_q;
    mask_d   = mask_q;
    widx_d   = widx_q;

    case (mode_q)
      MODE_WORD: begin
        if (is_word_char(byte_i)) begin
          mask_d = word_add(mask_q, widx_q, byte_i);
          widx_d = (widx_q == 4'hF) ? widx_q : widx_q + 1'b1;
        end else begin
          bundle_o.tok[n] = '{close_kind(mask_q, widx_q), sat_start(begin_q), span(cur, begin_q)};
          n       = n + 1'b1;
          mode_d  = MODE_IDLE;
          do_idle = 1'b1;
        end
      end
      MODE_STRING: begin
        if (byte_i == CH_QUOTE) begin
          bundle_o.tok[n] = '{KIND_STRING, sat_start(begin_q), span(cur, begin_q)};
          n      = n + 1'b1;
          mode_d = MODE_IDLE;
        end else if (byte_i == CH_BSL) begin
          mode_d = MODE_ESC;
        end
      end
      MODE_ESC: mode_d = MODE_STRING;
      default:  do_idle = 1'b1;
    endcase

    if (do_idle) begin
      for (int k = 0; k < NUM_PUNCT; k++) begin
        if (PUNCT[k] == byte_i) begin
          hit  = 1'b1;
          pidx = 4'(k);
        end
      end
      if (byte_i == CH_SPACE || byte_i == CH_TAB) begin
        // skipped
      end else if (hit) begin
        bundle_o.tok[n] = '{KIND_W'(pidx), sat_start(cur), LEN_W'(1)};
        n = n + 1'b1;
      end else if (byte_i == CH_QUOTE) begin
        mode_d  = MODE_STRING;
        begin_d = nxt;
      end else if (is_word_char(byte_i)) begin
        mode_d  = MODE_WORD;
        begin_d = cur;
        mask_d  = word_add(6'h3F, 4'd0, byte_i);
        widx_d  = 4'd1;
      end else begin
        bundle_o.tok[n] = '{KIND_OTHER, sat_start(cur), LEN_W'(1)};
        n = n + 1'b1;
      end
    end

    offset_d = nxt;

    if (line_end_i) begin
      if (mode_d == MODE_WORD) begin
        bundle_o.tok[n] = '{close_kind(mask_d, widx_d), sat_start(begin_d), span(nxt, begin_d)};
        n = n + 1'b1;
      end else if (mode_d == MODE_STRING || mode_d == MODE_ESC) begin
        bundle_o.tok[n] = '{KIND_UNTERM, sat_start(begin_d), span(nxt, begin_d)};
        n = n + 1'b1;
      end
      bundle_o.tok[n] = '{KIND_END, sat_start(nxt), LEN_W'(0)};
      n        = n + 1'b1;
      mode_d   = MODE_IDLE;
      offset_d = '0;
      begin_d  = '0;
      mask_d   = 6'h3F;
      widx_d   = '0;
    end

    bundle_o.cnt = n;
    push_o       = accept_i && (n != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      offset_q <= '0;
      begin_q  <= '0;
      mask_q   <= 6'h3F;
      widx_q   <= '0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      offset_q <= offset_d;
      begin_q  <= begin_d;
      mask_q   <= mask_d;
      widx_q   <= widx_d;
    end
  end

endmodule

### design/mll_queue.sv
module mll_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mll_pkg::bundle_t  bundle_i,
  output logic              full_o,
  output logic              head_valid_o,
  output mll_pkg::bundle_t  head_o,
  input  logic              pop_i
);
  import mll_pkg::*;

  bundle_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o       = (cnt_q == QCNT_W'(QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### design/mll_back.sv
module mll_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         head_valid_i,
  input  mll_pkg::bundle_t             head_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mll_pkg::KIND_W-1:0]   token_kind_o,
  output logic [mll_pkg::START_W-1:0]  token_start_o,
  output logic [mll_pkg::LEN_W-1:0]    token_length_o,
  output logic                         last_of_item_o
);
  import mll_pkg::*;

  logic [1:0]         sub_q;
  logic               valid_q;
  logic [KIND_W-1:0]  kind_q;
  logic [START_W-1:0] start_q;
  logic [LEN_W-1:0]   len_q;
  logic               last_q;
  logic               load;
  logic               is_last;

  assign load    = !valid_q || !out_stall_i;
  assign is_last = (sub_q == head_i.cnt - 2'd1);
  assign pop_o   = load && head_valid_i && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sub_q   <= '0;
    end else if (load) begin
      valid_q <= head_valid_i;
      if (head_valid_i) begin
        sub_q <= is_last ? 2'd0 : sub_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && head_valid_i) begin
      kind_q  <= head_i.tok[sub_q].kind;
      start_q <= head_i.tok[sub_q].start;
      len_q   <= head_i.tok[sub_q].length;
      last_q  <= is_last;
    end
  end

  assign out_valid_o    = valid_q;
  assign token_kind_o   = kind_q;
  assign token_start_o  = start_q;
  assign token_length_o = len_q;
  assign last_of_item_o = last_q;

endmodule

### design/mi_line_lexer_top.sv
// A byte's tokens are written into the bundle queue when the byte is accepted,
// and are then loaded one at a time into the serialiser's output registers.
// Throughput: one byte per cycle in while the queue is not full; one token per
// cycle out unless out_stall_i; a k-token byte holds the serialiser for all k.
// A four-entry bundle queue sits between the lexer front and the serialiser.
// Reset (async, active low) clears lexer state, queue pointers and output valid.
module mi_line_lexer_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   byte_in_i,
  input  logic                         line_end_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mll_pkg::KIND_W-1:0]   token_kind_o,
  output logic [mll_pkg::START_W-1:0]  token_start_o,
  output logic [mll_pkg::LEN_W-1:0]    token_length_o,
  output logic                         last_of_item_o
);
  import mll_pkg::*;

  logic    accept;
  logic    push;
  logic    full;
  logic    head_valid;
  logic    pop;
  bundle_t bundle;
  bundle_t head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  mll_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .byte_i     (byte_in_i),
    .line_end_i (line_end_i),
    .push_o     (push),
    .bundle_o   (bundle)
  );

  mll_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .bundle_i     (bundle),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  mll_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .token_start_o  (token_start_o),
    .token_length_o (token_length_o),
    .last_of_item_o (last_of_item_o)
  );

endmodule
